// ----- rtl/bfr_pkg.sv -----
// Shared types and constants for the bitstream field reader.
// Depends on nothing; the digit shifter, the reader and the testbench refer to it by scoped names.
`timescale 1ns / 1ps

package bfr_pkg;

  // Buffer geometry. The position addresses single bits of the whole buffer.
  localparam int BUFFER_BYTES = 4096;
  localparam int BUF_AW       = $clog2(BUFFER_BYTES);
  localparam int POS_W        = BUF_AW + 3;

  // Field widths of the item ports.
  localparam int CMD_W    = 2;
  localparam int COUNT_W  = 6;
  localparam int VALUE_W  = 32;
  localparam int NEXTPOS_W = 15;

  // Largest number of bits that one read may take.
  localparam logic [COUNT_W-1:0] READ_MAX_BITS = 6'd32;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REWIND = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SWAP_WORDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LSB_FIRST  = 2'd1;

  // Word swap flips the two low byte address bits.
  localparam logic [BUF_AW-1:0] SWAP_MASK = BUF_AW'(3);

  // Read sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DONE
  } state_t;

  // Controls from the sequencer to the digit shifter.
  typedef struct packed {
    logic               clear;
    logic               step;
    logic               lsb_first;
    logic [2:0]         offset;
    logic [3:0]         width;
    logic [COUNT_W-1:0] taken;
  } shift_ctrl_t;

endpackage

// ----- rtl/bfr_byte_ram.sv -----
// Byte buffer memory: one write port and one read port with registered data.
// Generic storage; no package dependency.
`timescale 1ns / 1ps

module bfr_byte_ram #(
  parameter int ADDR_W = 12,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered output.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bfr_digit_shifter.sv -----
// Value accumulator that takes up to eight bits of one buffer byte per cycle in which it is stepped.
// Depends on bfr_pkg for widths and the shift control struct.
`timescale 1ns / 1ps

module bfr_digit_shifter (
  input  logic                               clk,
  input  bfr_pkg::shift_ctrl_t               ctrl,
  input  logic [7:0]                         digit,
  output logic [bfr_pkg::VALUE_W-1:0]        acc
);

  logic [3:0]                  rshift;
  logic [7:0]                  mask;
  logic [7:0]                  chunk;
  logic [bfr_pkg::VALUE_W-1:0] acc_next;

  // Select the run of bits that this byte contributes, right aligned.
  always_comb begin
    mask = 8'((16'h1 << ctrl.width) - 16'h1);
    if (ctrl.lsb_first) begin
      rshift = {1'b0, ctrl.offset};
    end else begin
      rshift = 4'd8 - {1'b0, ctrl.offset} - ctrl.width;
    end
    chunk = (digit >> rshift) & mask;
  end

  // LSB first places the run above the bits already taken; MSB first shifts it in.
  always_comb begin
    if (ctrl.lsb_first) begin
      acc_next = acc | ({{(bfr_pkg::VALUE_W-8){1'b0}}, chunk} << ctrl.taken[4:0]);
    end else begin
      acc_next = (acc << ctrl.width) | {{(bfr_pkg::VALUE_W-8){1'b0}}, chunk};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.step) begin
      acc <= acc_next;
    end
  end

endmodule

// ----- rtl/bitstream_field_reader.sv -----
// Bitstream field reader: bit-granular reads from a loadable 4096-byte buffer.
// Load and rewind beats are taken while idle. A read over k buffer bytes (one to five)
// fetches and folds in one byte per cycle, then loads its result into the output register
// once that is free, taking no new beat before then; a zero-bit read skips the fetches.
// Reset clears the position to zero, swap_words to 0 and lsb_first to 1;
// buffer contents are undefined until loaded. Depends on bfr_pkg and submodules.
`timescale 1ns / 1ps

module bitstream_field_reader (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bfr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [7:0]                           cfg_data,
  // Input item channel.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [bfr_pkg::CMD_W-1:0]            cmd,
  input  logic [11:0]                          byte_addr,
  input  logic [7:0]                           byte_data,
  input  logic [bfr_pkg::COUNT_W-1:0]          bit_count,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [bfr_pkg::VALUE_W-1:0]          value,
  output logic [bfr_pkg::NEXTPOS_W-1:0]        next_position
);

  bfr_pkg::state_t             state;
  bfr_pkg::state_t             state_next;
  logic                        swap_words;
  logic                        lsb_first;
  logic [bfr_pkg::POS_W-1:0]   pos;
  logic [bfr_pkg::BUF_AW-1:0]  fetch_ptr;
  logic [bfr_pkg::COUNT_W-1:0] rem;
  logic [bfr_pkg::COUNT_W-1:0] taken;
  logic                        rd_pend;
  logic                        is_load;
  logic                        is_read;
  logic                        is_rewind;
  logic                        in_beat;
  logic                        start_read;
  logic                        result_load;
  logic                        consume;
  logic [bfr_pkg::COUNT_W-1:0] count_sat;
  logic [3:0]                  avail;
  logic [3:0]                  step_w;
  logic [bfr_pkg::BUF_AW-1:0]  rd_addr;
  logic [7:0]                  rd_data;
  logic [bfr_pkg::VALUE_W-1:0] acc;
  bfr_pkg::shift_ctrl_t        sh_ctrl;

  // Configuration writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_words <= 1'b0;
      lsb_first  <= 1'b1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bfr_pkg::CFG_SWAP_WORDS: swap_words <= cfg_data[0];
        bfr_pkg::CFG_LSB_FIRST:  lsb_first  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Command decode; the unused code does nothing.
  always_comb begin
    is_load   = 1'b0;
    is_read   = 1'b0;
    is_rewind = 1'b0;
    unique case (cmd)
      bfr_pkg::CMD_LOAD:   is_load   = 1'b1;
      bfr_pkg::CMD_READ:   is_read   = 1'b1;
      bfr_pkg::CMD_REWIND: is_rewind = 1'b1;
      default: ;
    endcase
  end

  assign in_beat   = in_valid && in_ready;
  assign count_sat = (bit_count > bfr_pkg::READ_MAX_BITS) ? bfr_pkg::READ_MAX_BITS : bit_count;

  // Bits this byte gives: the rest of the byte or the rest of the read.
  assign avail  = 4'd8 - {1'b0, pos[2:0]};
  assign step_w = ({2'b00, avail} < rem) ? avail : rem[3:0];

  // Sequencer: one byte fetched per cycle, folded in on the cycle after its fetch.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    start_read  = 1'b0;
    result_load = 1'b0;
    unique case (state)
      bfr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && is_read) begin
          start_read = 1'b1;
          if (count_sat == '0) begin
            state_next = bfr_pkg::S_DONE;
          end else begin
            state_next = bfr_pkg::S_READ;
          end
        end
      end
      bfr_pkg::S_READ: begin
        if (rd_pend && (rem == {2'b00, step_w})) begin
          state_next = bfr_pkg::S_DONE;
        end
      end
      bfr_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          result_load = 1'b1;
          state_next  = bfr_pkg::S_IDLE;
        end
      end
      default: state_next = bfr_pkg::S_IDLE;
    endcase
  end

  assign consume = (state == bfr_pkg::S_READ) && rd_pend;

  // Bit position; it wraps at the buffer size through its width.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (in_beat && is_rewind) begin
      pos <= '0;
    end else if (consume) begin
      pos <= pos + bfr_pkg::POS_W'(step_w);
    end
  end

  // Fetch pointer, remaining and taken bit counts of the current read.
  always_ff @(posedge clk) begin
    if (start_read) begin
      fetch_ptr <= pos[bfr_pkg::POS_W-1:3];
      rem       <= count_sat;
      taken     <= '0;
    end else begin
      if (state == bfr_pkg::S_READ) begin
        fetch_ptr <= fetch_ptr + bfr_pkg::BUF_AW'(1);
      end
      if (consume) begin
        rem   <= rem - bfr_pkg::COUNT_W'(step_w);
        taken <= taken + bfr_pkg::COUNT_W'(step_w);
      end
    end
  end

  // Read data is valid in the cycle after its address was issued.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= (state == bfr_pkg::S_READ);
    end
  end

  assign rd_addr = swap_words ? (fetch_ptr ^ bfr_pkg::SWAP_MASK) : fetch_ptr;

  bfr_byte_ram #(
    .ADDR_W (bfr_pkg::BUF_AW),
    .DATA_W (8)
  ) u_ram (
    .clk   (clk),
    .we    (in_beat && is_load),
    .waddr (byte_addr[bfr_pkg::BUF_AW-1:0]),
    .wdata (byte_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Shifter control for the byte now arriving.
  always_comb begin
    sh_ctrl.clear     = start_read;
    sh_ctrl.step      = consume;
    sh_ctrl.lsb_first = lsb_first;
    sh_ctrl.offset    = pos[2:0];
    sh_ctrl.width     = step_w;
    sh_ctrl.taken     = taken;
  end

  bfr_digit_shifter u_shifter (
    .clk   (clk),
    .ctrl  (sh_ctrl),
    .digit (rd_data),
    .acc   (acc)
  );

  // Output register holds a finished result until its beat is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      value         <= acc;
      next_position <= bfr_pkg::NEXTPOS_W'(pos);
    end
  end

endmodule

// ----- tb/bitstream_field_reader_tb.sv -----
// Self-checking testbench for bitstream_field_reader: buffer loads, rewinds and bit reads.
// A queue-fed driver, a randomly stalling result sink and an in-bench predictor of the
// buffer and bit position. Depends on bfr_pkg and the reader RTL.
`timescale 1ns / 1ps

module bitstream_field_reader_tb;

  // The one command code that the package leaves unnamed; the block ignores it.
  localparam logic [bfr_pkg::CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int BUFFER_BITS = bfr_pkg::BUFFER_BYTES * 8;
  // Bits covered by the closing run of full-width reads.
  localparam int SWEEP_BITS = 3200;

  typedef struct packed {
    logic [bfr_pkg::CMD_W-1:0]   cmd;
    logic [bfr_pkg::BUF_AW-1:0]  addr;
    logic [7:0]                  data;
    logic [bfr_pkg::COUNT_W-1:0] count;
  } command_t;

  typedef struct packed {
    logic [bfr_pkg::VALUE_W-1:0]   value;
    logic [bfr_pkg::NEXTPOS_W-1:0] pos;
  } read_result_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [bfr_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [7:0]                      cfg_data = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [bfr_pkg::CMD_W-1:0]       cmd = '0;
  logic [11:0]                     byte_addr = '0;
  logic [7:0]                      byte_data = '0;
  logic [bfr_pkg::COUNT_W-1:0]     bit_count = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [bfr_pkg::VALUE_W-1:0]     value;
  logic [bfr_pkg::NEXTPOS_W-1:0]   next_position;

  // Commands waiting to be driven and read results waiting to come out.
  command_t     pending_cmds[$];
  read_result_t pending_reads[$];

  // Predicted block state, advanced as beats are accepted.
  logic [7:0]                shadow_buf [bfr_pkg::BUFFER_BYTES];
  logic [bfr_pkg::POS_W-1:0] read_pos = '0;
  logic                      swap_on = 1'b0;
  logic                      lsb_on = 1'b1;

  // Stimulus planning state: position and loaded bytes as of the last queued command.
  int plan_pos = 0;
  bit plan_loaded [bfr_pkg::BUFFER_BYTES];
  int queued = 0;

  logic in_beat = 1'b0;
  logic out_beat = 1'b0;
  logic sender_hold = 1'b0;
  logic sink_hold = 1'b0;
  int   accepted = 0;
  int   errors = 0;
  int   send_gap = 0;
  int   send_burst = 0;
  int   sink_gap = 0;
  int   sink_burst = 0;
  command_t drive_cmd;

  bitstream_field_reader dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .byte_addr(byte_addr),
    .byte_data(byte_data), .bit_count(bit_count),
    .out_valid(out_valid), .out_ready(out_ready), .value(value), .next_position(next_position)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Extracts up to 32 bits at the predicted position and advances it.
  function automatic read_result_t take_bits(input logic [bfr_pkg::COUNT_W-1:0] count);
    read_result_t               r;
    logic [bfr_pkg::BUF_AW-1:0] a;
    logic [2:0]                 sel;
    int                         n;
    r = '0;
    n = (count > bfr_pkg::READ_MAX_BITS) ? int'(bfr_pkg::READ_MAX_BITS) : int'(count);
    for (int i = 0; i < n; i++) begin
      a = read_pos[bfr_pkg::POS_W-1:3];
      if (swap_on) a = a ^ bfr_pkg::SWAP_MASK;
      sel = lsb_on ? read_pos[2:0] : 3'd7 - read_pos[2:0];
      if (lsb_on) r.value[i] = shadow_buf[a][sel];
      else r.value = {r.value[bfr_pkg::VALUE_W-2:0], shadow_buf[a][sel]};
      read_pos = read_pos + bfr_pkg::POS_W'(1);
    end
    r.pos = bfr_pkg::NEXTPOS_W'(read_pos);
    return r;
  endfunction

  // Idle cycles before the next beat: mostly uniform, with runs of back-to-back beats.
  function automatic int draw_pause(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  task automatic log_error(input string msg);
    errors++;
    if (errors <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic queue_cmd(input logic [bfr_pkg::CMD_W-1:0] c,
                           input logic [bfr_pkg::BUF_AW-1:0] a,
                           input logic [7:0] d, input logic [bfr_pkg::COUNT_W-1:0] n);
    pending_cmds.push_back('{c, a, d, n});
    queued++;
    if (c == bfr_pkg::CMD_LOAD) plan_loaded[a] = 1'b1;
    else if (c == bfr_pkg::CMD_REWIND) plan_pos = 0;
  endtask

  // Rewind or unused command, with random contents in the fields it ignores.
  task automatic queue_bare(input logic [bfr_pkg::CMD_W-1:0] c);
    queue_cmd(c, bfr_pkg::BUF_AW'($urandom), 8'($urandom), bfr_pkg::COUNT_W'($urandom));
  endtask

  // A read, preceded by loads of any byte it would touch that holds nothing yet.
  task automatic queue_read(input logic [bfr_pkg::COUNT_W-1:0] n);
    int                         bits;
    logic [bfr_pkg::BUF_AW-1:0] a;
    bits = (n > bfr_pkg::READ_MAX_BITS) ? int'(bfr_pkg::READ_MAX_BITS) : int'(n);
    for (int i = 0; i < bits; i++) begin
      a = bfr_pkg::BUF_AW'(((plan_pos + i) % BUFFER_BITS) >> 3);
      if (swap_on) a = a ^ bfr_pkg::SWAP_MASK;
      if (!plan_loaded[a]) begin
        queue_cmd(bfr_pkg::CMD_LOAD, a, 8'($urandom), bfr_pkg::COUNT_W'($urandom));
      end
    end
    queue_cmd(bfr_pkg::CMD_READ, bfr_pkg::BUF_AW'($urandom), 8'($urandom), n);
    plan_pos = (plan_pos + bits) % BUFFER_BITS;
  endtask

  // Random mix: mostly reads, loads anywhere and just ahead of the position, some noise.
  task automatic queue_random(input int total);
    int start;
    int pick;
    int r;
    start = queued;
    while (queued - start < total) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        r = $urandom_range(0, 9);
        if (r == 0) queue_read(bfr_pkg::COUNT_W'($urandom_range(33, 63)));
        else if (r == 1) queue_read('0);
        else queue_read(bfr_pkg::COUNT_W'($urandom_range(1, 32)));
      end else if (pick < 70) begin
        queue_cmd(bfr_pkg::CMD_LOAD, bfr_pkg::BUF_AW'($urandom), 8'($urandom),
                  bfr_pkg::COUNT_W'($urandom));
      end else if (pick < 82) begin
        queue_cmd(bfr_pkg::CMD_LOAD,
                  bfr_pkg::BUF_AW'((plan_pos >> 3) + $urandom_range(0, 8)), 8'($urandom),
                  bfr_pkg::COUNT_W'($urandom));
      end else if (pick < 90) begin
        queue_bare(bfr_pkg::CMD_REWIND);
      end else if (pick < 95) begin
        queue_bare(CMD_NOP);
      end else begin
        queue_cmd(bfr_pkg::CMD_LOAD, bfr_pkg::BUF_AW'($urandom),
                  $urandom_range(0, 1) ? 8'hFF : 8'h00, bfr_pkg::COUNT_W'($urandom));
      end
    end
  endtask

  // Register writes happen only with the block idle.
  task automatic write_reg(input logic [bfr_pkg::CFG_IDX_W-1:0] idx, input logic bit_val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= {7'($urandom), bit_val};
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == bfr_pkg::CFG_SWAP_WORDS) swap_on = bit_val;
    else lsb_on = bit_val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits for the input to go quiet and every read result to arrive, then lets the
  // block finish any load or rewind still in hand.
  task automatic wait_quiet(input bit all_sent);
    do @(posedge clk);
    while (in_valid || pending_reads.size() != 0 || (all_sent && pending_cmds.size() != 0));
    repeat (12) @(posedge clk);
  endtask

  // Driver: offers the next queued command after its drawn gap and holds it until taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat) begin
      if (send_gap > 0 || sender_hold || pending_cmds.size() == 0) begin
        if (send_gap > 0) send_gap--;
        in_valid <= 1'b0;
      end else begin
        drive_cmd = pending_cmds.pop_front();
        cmd       <= drive_cmd.cmd;
        byte_addr <= drive_cmd.addr;
        byte_data <= drive_cmd.data;
        bit_count <= drive_cmd.count;
        in_valid  <= 1'b1;
        send_gap  = draw_pause(send_burst);
      end
    end
  end

  // Result sink: stalls for a drawn number of cycles after each beat.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_beat) sink_gap = draw_pause(sink_burst);
      else if (sink_gap > 0) sink_gap--;
      out_ready <= (sink_gap == 0) && !sink_hold;
    end
  end

  // Monitor: checks each result beat against the oldest expectation, then predicts
  // the effect of each accepted command.
  always @(posedge clk) begin
    read_result_t want;
    in_beat  <= !rst && in_valid && in_ready;
    out_beat <= !rst && out_valid && out_ready;
    if (!rst && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        log_error($sformatf("result with none expected: value %h next_position %h",
                            value, next_position));
      end else begin
        want = pending_reads.pop_front();
        if (value !== want.value)
          log_error($sformatf("value: expected %h, got %h", want.value, value));
        if (next_position !== want.pos)
          log_error($sformatf("next_position: expected %h, got %h", want.pos, next_position));
      end
    end
    if (!rst && in_valid && in_ready) begin
      accepted++;
      case (cmd)
        bfr_pkg::CMD_LOAD:   shadow_buf[byte_addr] = byte_data;
        bfr_pkg::CMD_READ:   pending_reads.push_back(take_bits(bit_count));
        bfr_pkg::CMD_REWIND: read_pos = '0;
        default:             ;
      endcase
    end
  end

  // Long sink hold-off so that the block backs up and stalls its input.
  initial begin : sink_holdoff
    do @(posedge clk); while (accepted < 200);
    sink_hold = 1'b1;
    repeat (400) @(posedge clk);
    sink_hold = 1'b0;
  end

  initial begin : watchdog
    #(8_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] pat [8];
    int         swept;
    pat = '{8'hA5, 8'hFF, 8'h00, 8'h3C, 8'h81, 8'h5A, 8'h7E, 8'hC3};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    repeat (3) @(posedge clk);

    // Directed part in the reset mode: zero count, short and full reads, a read over
    // five bytes, an oversized count, the last address, the unused command and rewinds.
    for (int i = 0; i < 8; i++) begin
      queue_cmd(bfr_pkg::CMD_LOAD, bfr_pkg::BUF_AW'(i), pat[i], bfr_pkg::COUNT_W'($urandom));
    end
    queue_read(6'd0);
    queue_read(6'd1);
    queue_read(6'd7);
    queue_read(6'd32);
    queue_bare(CMD_NOP);
    queue_bare(bfr_pkg::CMD_REWIND);
    queue_read(6'd3);
    queue_read(6'd32);
    queue_read(6'd63);
    queue_cmd(bfr_pkg::CMD_LOAD, bfr_pkg::BUF_AW'(bfr_pkg::BUFFER_BYTES - 1), 8'hFF, 6'd63);
    queue_read(6'd33);
    queue_bare(bfr_pkg::CMD_REWIND);
    queue_read(6'd0);
    wait_quiet(1'b1);

    // Random phases over every mode setting.
    write_reg(bfr_pkg::CFG_SWAP_WORDS, 1'b1);
    write_reg(bfr_pkg::CFG_LSB_FIRST, 1'b1);
    queue_random(350);
    wait_quiet(1'b1);

    // This phase also pauses the sender midway until every result is out.
    write_reg(bfr_pkg::CFG_SWAP_WORDS, 1'b0);
    write_reg(bfr_pkg::CFG_LSB_FIRST, 1'b0);
    queue_random(350);
    do @(posedge clk); while (pending_cmds.size() > 200);
    sender_hold = 1'b1;
    wait_quiet(1'b0);
    sender_hold = 1'b0;
    wait_quiet(1'b1);

    write_reg(bfr_pkg::CFG_SWAP_WORDS, 1'b1);
    write_reg(bfr_pkg::CFG_LSB_FIRST, 1'b0);
    queue_random(350);
    wait_quiet(1'b1);

    write_reg(bfr_pkg::CFG_SWAP_WORDS, 1'b0);
    write_reg(bfr_pkg::CFG_LSB_FIRST, 1'b1);
    queue_random(350);
    wait_quiet(1'b1);

    // A long run of full-width reads from an unaligned start, so that every read
    // straddles byte and word boundaries in the swapped, MSB-first mode.
    write_reg(bfr_pkg::CFG_SWAP_WORDS, 1'b1);
    write_reg(bfr_pkg::CFG_LSB_FIRST, 1'b0);
    queue_bare(bfr_pkg::CMD_REWIND);
    queue_read(6'd5);
    swept = 5;
    while (swept < SWEEP_BITS) begin
      if ($urandom_range(0, 3) == 0) queue_read(bfr_pkg::COUNT_W'($urandom_range(33, 63)));
      else queue_read(6'd32);
      if ($urandom_range(0, 15) == 0) begin
        queue_cmd(bfr_pkg::CMD_LOAD, bfr_pkg::BUF_AW'($urandom), 8'($urandom),
                  bfr_pkg::COUNT_W'($urandom));
      end
      swept += 32;
    end
    wait_quiet(1'b1);

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- bitstream_field_reader.f -----
rtl/bfr_pkg.sv
rtl/bfr_byte_ram.sv
rtl/bfr_digit_shifter.sv
rtl/bitstream_field_reader.sv
tb/bitstream_field_reader_tb.sv
